### hdl/assert_macros.svh
// Assertion macros shared by the Scale2x upscaler RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define S2X_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that must also hold during reset.
`define S2X_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### hdl/s2x_pkg.sv
// Shared types, constants and register indexes of the Scale2x upscaler.
// No dependencies; imported by every module of the block except s2x_ram.
`timescale 1ns / 1ps

package s2x_pkg;

   localparam int PIX_W          = 32;
   localparam int RGB_W          = 24;
   localparam int ROW_W          = 16;
   localparam int SRC_COL_W      = 10;
   localparam int WIDTH_REG_W    = 11;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = 16;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int NUM_BLK        = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH  = 11'd1024;
   localparam logic [ROW_W-1:0]       RESET_HEIGHT = 16'd1024;

   // Bit positions of the pending-block mask, in output order.
   localparam int BLK_UPPER = 0;   // block of the row above
   localparam int BLK_LEFT  = 1;   // last row: block of the previous column
   localparam int BLK_HERE  = 2;   // last row, last column: own block

   typedef logic [PIX_W-1:0] pix_type;

   // One line store entry: the row before the previous one and the previous row.
   typedef struct packed {
      pix_type older;
      pix_type prev;
   } line_word_type;

   // Centre and its four neighbours.
   typedef struct packed {
      pix_type e;
      pix_type b;
      pix_type d;
      pix_type f;
      pix_type h;
   } nbhd_type;

   typedef struct packed {
      pix_type tl;
      pix_type tr;
      pix_type bl;
      pix_type br;
   } quad_type;

   // Everything the output stage needs about one accepted pixel.
   typedef struct packed {
      pix_type              pixel;
      pix_type              cen_older;
      pix_type              cen_prev;
      pix_type              left;
      pix_type              right;
      pix_type              held;
      pix_type              held2;
      logic [ROW_W-1:0]     row;
      logic                 has_up;
      logic                 has_up2;
      logic                 has_left;
      logic                 has_left2;
      logic                 has_right;
      logic [NUM_BLK-1:0]   blk_mask;
   } item_type;

endpackage

### hdl/s2x_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; read-before-write on an address collision.
`timescale 1ns / 1ps

module s2x_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/s2x_kernel.sv
// Scale2x rule: turns a centre pixel and its four neighbours into a 2x2 block.
// Depends on s2x_pkg; purely combinational.
`timescale 1ns / 1ps

module s2x_kernel (
   input  s2x_pkg::nbhd_type nb,
   output s2x_pkg::quad_type quad
);

   import s2x_pkg::*;

   // Neighbours are compared on colour only; alpha is ignored.
   function automatic logic same_rgb(input pix_type a, input pix_type b);
      return a[RGB_W-1:0] == b[RGB_W-1:0];
   endfunction

   always_comb begin
      quad.tl = nb.e;
      quad.tr = nb.e;
      quad.bl = nb.e;
      quad.br = nb.e;
      if (!same_rgb(nb.b, nb.h) && !same_rgb(nb.d, nb.f)) begin
         if (same_rgb(nb.d, nb.b)) begin
            quad.tl = nb.d;
         end
         if (same_rgb(nb.b, nb.f)) begin
            quad.tr = nb.f;
         end
         if (same_rgb(nb.d, nb.h)) begin
            quad.bl = nb.d;
         end
         if (same_rgb(nb.h, nb.f)) begin
            quad.br = nb.f;
         end
      end
   end

endmodule

### hdl/s2x_front.sv
// Position counters, two-row line store and neighbourhood window registers.
// Depends on s2x_pkg and s2x_ram; produces one item_type per accepted pixel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s2x_front #(
   parameter int MAX_WIDTH = s2x_pkg::DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        accept,
   input  s2x_pkg::pix_type            pixel,
   input  logic [WID_W-1:0]            width_eff,
   input  logic [s2x_pkg::ROW_W-1:0]   height_eff,
   output s2x_pkg::item_type           item,
   output logic [COL_W-1:0]            item_col
);

   import s2x_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   line_word_type    cen_ff, cen_in;
   line_word_type    row_start_ff, row_start_in;
   line_word_type    fwd_data_ff;
   line_word_type    ram_rd, right_word, wr_word;
   pix_type          left_ff, held_ff, held2_ff;
   logic             fwd_sel_ff, fwd_sel_in;
   logic [COL_W-1:0] rd_addr;
   logic [WID_W-1:0] col_ext;
   logic             last_col, last_row, has_right;

   assign col_ext   = WID_W'(col_ff);
   assign last_col  = (col_ext == width_eff - 1'b1);
   assign has_right = ((col_ext + 1'b1) < width_eff);
   assign last_row  = (row_ff == height_eff - 1'b1);

   // The entry at the current column moves up one row when the new pixel lands.
   assign wr_word.older = cen_ff.prev;
   assign wr_word.prev  = pixel;

   // The entry to the right was fetched last cycle; forward it if it was also
   // written in that cycle.
   assign right_word   = fwd_sel_ff ? fwd_data_ff : ram_rd;
   assign row_start_in = (accept && (col_ff == '0)) ? wr_word : row_start_ff;

   always_comb begin
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
         cen_in = row_start_ff;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
            cen_in = row_start_in;
         end else begin
            col_in = col_ff + 1'b1;
            row_in = row_ff;
            cen_in = right_word;
         end
      end else begin
         col_in = col_ff;
         row_in = row_ff;
         cen_in = cen_ff;
      end
   end

   assign rd_addr    = col_in + 1'b1;
   assign fwd_sel_in = accept && (rd_addr == col_ff);

   s2x_ram #(
      .WIDTH($bits(line_word_type)),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         fwd_sel_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         fwd_sel_ff <= fwd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cen_ff       <= cen_in;
      row_start_ff <= row_start_in;
      fwd_data_ff  <= wr_word;
      if (accept) begin
         left_ff  <= cen_ff.prev;
         held_ff  <= pixel;
         held2_ff <= held_ff;
      end
   end

   always_comb begin
      item.pixel     = pixel;
      item.cen_older = cen_ff.older;
      item.cen_prev  = cen_ff.prev;
      item.left      = left_ff;
      item.right     = right_word.prev;
      item.held      = held_ff;
      item.held2     = held2_ff;
      item.row       = row_ff;
      item.has_up    = (row_ff != '0);
      item.has_up2   = (row_ff >= ROW_W'(2));
      item.has_left  = (col_ff != '0);
      item.has_left2 = (col_ext >= WID_W'(2));
      item.has_right = has_right;
      item.blk_mask  = '0;
      item.blk_mask[BLK_UPPER] = (row_ff != '0);
      item.blk_mask[BLK_LEFT]  = last_row && (col_ff != '0);
      item.blk_mask[BLK_HERE]  = last_row && last_col;
   end

   assign item_col = col_ff;

   `S2X_ASSERT_CLK(a_col_in_row, clock, reset, col_ext < width_eff,
      "column counter beyond the row width")
   `S2X_ASSERT_CLK(a_row_in_frame, clock, reset, row_ff < height_eff,
      "row counter beyond the frame height")
   `S2X_ASSERT_ALWAYS(a_restart_clears, clock, restart |=> (col_ff == '0 && row_ff == '0),
      "register write did not restart the frame")

endmodule

### hdl/s2x_emit.sv
// Item register and result register: sends the zero to three blocks of an item.
// Depends on s2x_pkg and s2x_kernel.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s2x_emit #(
   parameter int MAX_WIDTH = s2x_pkg::DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  s2x_pkg::item_type               item_in,
   input  logic [COL_W-1:0]                col_in,
   output logic                            load_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output s2x_pkg::quad_type               rsp_quad,
   output logic [s2x_pkg::SRC_COL_W-1:0]   rsp_col,
   output logic [s2x_pkg::ROW_W-1:0]       rsp_row,
   output logic                            rsp_last
);

   import s2x_pkg::*;

   typedef enum logic [1:0] {
      SEL_UPPER,
      SEL_LEFT,
      SEL_HERE
   } sel_type;

   item_type               item_ff;
   logic [COL_W-1:0]       col_ff;
   logic [NUM_BLK-1:0]     pend_ff, pend_in, pend_after, pend_low;
   sel_type                sel;
   nbhd_type               nb;
   quad_type               quad;
   logic [COL_W-1:0]       blk_col;
   logic [COL_W+SRC_COL_W-1:0] blk_col_wide;
   logic [ROW_W-1:0]       blk_row;
   logic                   out_free, fire;
   logic                   rsp_valid_ff, rsp_last_ff;
   quad_type               rsp_quad_ff;
   logic [SRC_COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]       rsp_row_ff;

   // Blocks go out in raster order: the row above first.
   always_comb begin
      priority if (pend_ff[BLK_UPPER]) begin
         sel = SEL_UPPER;
      end else if (pend_ff[BLK_LEFT]) begin
         sel = SEL_LEFT;
      end else begin
         sel = SEL_HERE;
      end
   end

   assign pend_low   = pend_ff & (~pend_ff + 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fire       = (pend_ff != '0) && out_free;
   assign pend_after = fire ? (pend_ff & ~pend_low) : pend_ff;
   assign load_ready = (pend_after == '0);
   assign pend_in    = load ? item_in.blk_mask : pend_after;

   // Missing neighbours at the image border are replaced by the centre.
   always_comb begin
      unique case (sel)
         SEL_UPPER: begin
            nb.e    = item_ff.cen_prev;
            nb.b    = item_ff.has_up2   ? item_ff.cen_older : item_ff.cen_prev;
            nb.d    = item_ff.has_left  ? item_ff.left      : item_ff.cen_prev;
            nb.f    = item_ff.has_right ? item_ff.right     : item_ff.cen_prev;
            nb.h    = item_ff.pixel;
            blk_col = col_ff;
            blk_row = item_ff.row - 1'b1;
         end
         SEL_LEFT: begin
            nb.e    = item_ff.held;
            nb.b    = item_ff.has_up    ? item_ff.left  : item_ff.held;
            nb.d    = item_ff.has_left2 ? item_ff.held2 : item_ff.held;
            nb.f    = item_ff.pixel;
            nb.h    = item_ff.held;
            blk_col = col_ff - 1'b1;
            blk_row = item_ff.row;
         end
         SEL_HERE: begin
            nb.e    = item_ff.pixel;
            nb.b    = item_ff.has_up   ? item_ff.cen_prev : item_ff.pixel;
            nb.d    = item_ff.has_left ? item_ff.held     : item_ff.pixel;
            nb.f    = item_ff.pixel;
            nb.h    = item_ff.pixel;
            blk_col = col_ff;
            blk_row = item_ff.row;
         end
         default: begin
            nb.e    = item_ff.pixel;
            nb.b    = item_ff.pixel;
            nb.d    = item_ff.pixel;
            nb.f    = item_ff.pixel;
            nb.h    = item_ff.pixel;
            blk_col = col_ff;
            blk_row = item_ff.row;
         end
      endcase
   end

   assign blk_col_wide = (COL_W + SRC_COL_W)'(blk_col);

   s2x_kernel u_kernel (
      .nb   (nb),
      .quad (quad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= fire || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
         col_ff  <= col_in;
      end
      if (fire) begin
         rsp_quad_ff <= quad;
         rsp_col_ff  <= blk_col_wide[SRC_COL_W-1:0];
         rsp_row_ff  <= blk_row;
         rsp_last_ff <= (pend_after == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_quad  = rsp_quad_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_last  = rsp_last_ff;

   `S2X_ASSERT_CLK(a_last_marks_end, clock, reset,
      (fire && pend_after == '0) |=> (rsp_valid_ff && rsp_last_ff),
      "final block of an item not marked as last")

endmodule

### hdl/scale2x_pixel_upscaler_top.sv
// Top level of the Scale2x pixel-art upscaler.
// Depends on s2x_pkg, s2x_front, s2x_emit, s2x_kernel and s2x_ram.
`timescale 1ns / 1ps

// Source RGBA pixels enter in raster order on the req_ channel, one per transfer.
// Each source pixel becomes a 2x2 block on the rsp_ channel, tagged with its
// source column and row; rsp_last_of_run marks the final block of a transfer.
// The block of row r-1 leaves when the pixel below it arrives, so the first row
// of a taller frame produces nothing. In the last row each pixel also releases
// the block of the pixel to its left, and the final pixel releases its own too.
// The first block of a transfer is built from the item register and waits in the
// result register before it shows on rsp_; further blocks of it follow in order.
// Throughput: one pixel per cycle while each transfer yields at most one block
// and rsp_ready stays high. In the last row a transfer yields up to two blocks,
// and the final pixel up to three; as the single result register sends at most
// one block a cycle, req_ready stays low until the extra blocks have gone out.
// Image width and height are set through csr_ (index 0: width, index 1:
// height); a write restarts the frame at row 0, column 0. Writes belong only
// to an idle block. Reset restores 1024 x 1024 and row 0, column 0; the line
// store needs no clearing pass, as a row is always written before it is read.
// When the receiver stalls, the pending result holds and req_ready drops
// once the item register has blocks still waiting to go out.
module scale2x_pixel_upscaler_top #(
   parameter int MAX_WIDTH = s2x_pkg::DEF_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  s2x_pkg::pix_type                 req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output s2x_pkg::pix_type                 rsp_top_left,
   output s2x_pkg::pix_type                 rsp_top_right,
   output s2x_pkg::pix_type                 rsp_bottom_left,
   output s2x_pkg::pix_type                 rsp_bottom_right,
   output logic [s2x_pkg::SRC_COL_W-1:0]    rsp_src_col,
   output logic [s2x_pkg::ROW_W-1:0]        rsp_src_row,
   output logic                             rsp_last_of_run,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [s2x_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [s2x_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import s2x_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WID_W > WIDTH_REG_W) ? WID_W : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0]       height_ff, height_in;
   logic [CMP_W-1:0]       width_cmp;
   logic [WID_W-1:0]       width_eff;
   logic [ROW_W-1:0]       height_eff;
   logic                   csr_fire, restart, accept;
   item_type               item;
   logic [COL_W-1:0]       item_col;
   quad_type               quad;

   // Register writes are always taken; a write to an unknown index is dropped.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[WIDTH_REG_W-1:0];
               restart  = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // A zero width or height acts as one; a width above the line store size is
   // clipped to it.
   assign width_cmp = CMP_W'(width_ff);

   always_comb begin
      priority if (width_ff == '0) begin
         width_eff = WID_W'(1);
      end else if (width_cmp > CMP_W'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(width_ff);
      end
   end

   assign height_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;

   assign accept = req_valid && req_ready;

   s2x_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .accept     (accept),
      .pixel      (req_pixel),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .item       (item),
      .item_col   (item_col)
   );

   s2x_emit #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .item_in    (item),
      .col_in     (item_col),
      .load_ready (req_ready),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_quad   (quad),
      .rsp_col    (rsp_src_col),
      .rsp_row    (rsp_src_row),
      .rsp_last   (rsp_last_of_run)
   );

   assign rsp_top_left     = quad.tl;
   assign rsp_top_right    = quad.tr;
   assign rsp_bottom_left  = quad.bl;
   assign rsp_bottom_right = quad.br;

endmodule

### verif/scale2x_pixel_upscaler_top_tb.sv
// Self-checking testbench for the Scale2x pixel upscaler top level.
// Depends on s2x_pkg and scale2x_pixel_upscaler_top; a scoreboard class predicts each 2x2 block.
`timescale 1ns / 1ps

module scale2x_pixel_upscaler_top_tb;
   import s2x_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int MAX_W        = DEF_MAX_WIDTH;
   localparam int HOLD_OFF     = 8;      // settle cycles before a register write
   localparam int STALL_LIMIT  = 2000;   // cycles without any transfer before giving up
   localparam int RANDOM_ITEMS = 195;
   localparam int WIDE_ITEMS   = 16;
   localparam int REPORT_MAX   = 10;

   // Index that addresses no register; a write to it must leave the frame position alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 4'hF;

   // One 2x2 output block as it leaves the rsp_ channel.
   typedef struct packed {
      pix_type                tl;
      pix_type                tr;
      pix_type                bl;
      pix_type                br;
      logic [SRC_COL_W-1:0]   col;
      logic [ROW_W-1:0]       row;
      logic                   last;
   } block_type;

   // Scoreboard: keeps its own copy of the line stores and frame position, expands
   // every accepted source pixel into the blocks it releases and checks them in order.
   class upscale_board;
      pix_type            prev_line [MAX_W];
      pix_type            older_line[MAX_W];
      int unsigned        col_pos;
      int unsigned        row_pos;
      pix_type            held_pix;
      pix_type            upper_left;
      logic [WIDTH_REG_W-1:0] width_reg;
      logic [ROW_W-1:0]   height_reg;
      block_type          blocks_due[$];
      int                 mismatches;

      function new();
         foreach (prev_line[i]) begin
            prev_line[i]  = '0;
            older_line[i] = '0;
         end
         col_pos    = 0;
         row_pos    = 0;
         held_pix   = '0;
         upper_left = '0;
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         mismatches = 0;
      endfunction

      function bit rgb_equal(pix_type a, pix_type b);
         return a[RGB_W-1:0] == b[RGB_W-1:0];
      endfunction

      // Applies the Scale2x rule to centre e with neighbours b (up), d (left),
      // f (right) and h (down).
      function block_type expand(pix_type e, pix_type b, pix_type d, pix_type f,
                                 pix_type h, int unsigned col, int unsigned row);
         block_type blk;
         blk.tl = e;
         blk.tr = e;
         blk.bl = e;
         blk.br = e;
         if (!rgb_equal(b, h) && !rgb_equal(d, f)) begin
            if (rgb_equal(d, b)) blk.tl = d;
            if (rgb_equal(b, f)) blk.tr = f;
            if (rgb_equal(d, h)) blk.bl = d;
            if (rgb_equal(h, f)) blk.br = f;
         end
         blk.col  = SRC_COL_W'(col);
         blk.row  = ROW_W'(row);
         blk.last = 1'b0;
         return blk;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else if (idx == CSR_IMAGE_HEIGHT) begin
            height_reg = data;
         end else begin
            return;
         end
         col_pos = 0;
         row_pos = 0;
      endfunction

      function void note_pixel(pix_type p);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned r;
         int          first_new;
         bit          last_row;
         pix_type     e;
         pix_type     b;
         pix_type     d;
         pix_type     f;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
         h = (height_reg == 0) ? 1 : height_reg;
         c = col_pos;
         r = row_pos;
         if (c >= w) c = w - 1;
         if (r >= h) r = h - 1;
         last_row  = (r == h - 1);
         first_new = blocks_due.size();

         // The block of the pixel above becomes complete now that its lower neighbour is known.
         if (r >= 1) begin
            e = prev_line[c];
            b = (r >= 2) ? older_line[c] : e;
            d = (c >= 1) ? upper_left : e;
            f = (c + 1 < w) ? prev_line[c + 1] : e;
            blocks_due.push_back(expand(e, b, d, f, p, c, r - 1));
         end

         upper_left    = prev_line[c];
         older_line[c] = prev_line[c];
         prev_line[c]  = p;

         // In the bottom row the left neighbour's block waits for its right neighbour.
         if (last_row && c >= 1) begin
            e = held_pix;
            b = (r >= 1) ? older_line[c - 1] : e;
            d = (c >= 2) ? prev_line[c - 2] : e;
            blocks_due.push_back(expand(e, b, d, p, e, c - 1, r));
         end

         // The bottom right pixel releases its own block straight away.
         if (last_row && c == w - 1) begin
            b = (r >= 1) ? older_line[c] : p;
            d = (c >= 1) ? prev_line[c - 1] : p;
            blocks_due.push_back(expand(p, b, d, p, p, c, r));
         end

         held_pix = p;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col_pos = c;
         row_pos = r;

         if (blocks_due.size() > first_new) blocks_due[blocks_due.size() - 1].last = 1'b1;
      endfunction

      function void check_block(block_type got);
         block_type want;
         if (blocks_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected block col %0d row %0d", $realtime, got.col, got.row);
            return;
         end
         want = blocks_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("%0t: expected tl %h tr %h bl %h br %h col %0d row %0d last %b",
                        $realtime, want.tl, want.tr, want.bl, want.br, want.col, want.row,
                        want.last);
               $display("%0t: actual   tl %h tr %h bl %h br %h col %0d row %0d last %b",
                        $realtime, got.tl, got.tr, got.bl, got.br, got.col, got.row,
                        got.last);
            end
         end
      endfunction

      function int pending();
         return blocks_due.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   pix_type                 req_pixel;
   logic                    rsp_valid;
   logic                    rsp_ready;
   pix_type                 rsp_top_left;
   pix_type                 rsp_top_right;
   pix_type                 rsp_bottom_left;
   pix_type                 rsp_bottom_right;
   logic [SRC_COL_W-1:0]    rsp_src_col;
   logic [ROW_W-1:0]        rsp_src_row;
   logic                    rsp_last_of_run;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   upscale_board board;
   int           quiet_cycles;   // consecutive cycles with no transfer on any channel
   int           ready_run;      // cycles left before the receiver changes its mind
   bit           burst_mode;     // when set the sender presents pixels back to back
   pix_type      palette[4];

   scale2x_pixel_upscaler_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_left     (rsp_top_left),
      .rsp_top_right    (rsp_top_right),
      .rsp_bottom_left  (rsp_bottom_left),
      .rsp_bottom_right (rsp_bottom_right),
      .rsp_src_col      (rsp_src_col),
      .rsp_src_row      (rsp_src_row),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // All three channels are observed from this one process, so that at any edge a
   // register write or a source pixel is applied to the prediction before the result
   // transfer of the same edge is checked. The stall counter lives here as well.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) board.note_pixel(req_pixel);
         if (rsp_valid && rsp_ready)
            board.check_block('{rsp_top_left, rsp_top_right, rsp_bottom_left,
                                rsp_bottom_right, rsp_src_col, rsp_src_row,
                                rsp_last_of_run});
         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver alternates between open stretches and stalls. Stalls vary in length
   // and a few are long; now and then it stays open for a long stretch.
   always @(negedge clock) begin
      if (ready_run > 0) begin
         ready_run = ready_run - 1;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         if ($urandom_range(0, 9) < 7)
            ready_run = $urandom_range(0, 2);
         else if ($urandom_range(0, 2) != 0)
            ready_run = $urandom_range(3, 6);
         else
            ready_run = $urandom_range(10, 40);
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            ready_run = $urandom_range(40, 150);
         else
            ready_run = $urandom_range(1, 8);
      end
   end

   // Watchdog: a healthy run never goes this long without any transfer.
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("scale2x_pixel_upscaler_top: mismatch");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly colours from a small palette with random alpha, so that neighbours often
   // match on RGB while differing in alpha; the rest is arbitrary noise.
   function automatic pix_type make_pixel();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return {8'($urandom_range(0, 255)), palette[$urandom_range(0, 3)][RGB_W-1:0]};
   endfunction

   function automatic void new_palette();
      foreach (palette[i]) palette[i] = $urandom;
   endfunction

   // Presents one source pixel after a random gap and holds it until the transfer.
   task automatic drive_pixel(input pix_type p);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops the sender and waits until every predicted block has been received.
   // With settle set it also lets the pipeline run dry, as a pixel of the top row
   // may still be in flight without any block waiting for it.
   task automatic wait_quiet(input bit settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      if (settle) repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [CSR_DATA_W-1:0] width_word,
                           input logic [CSR_DATA_W-1:0] height_word);
      if ($urandom_range(0, 1)) begin
         write_register(CSR_IMAGE_WIDTH, width_word);
         write_register(CSR_IMAGE_HEIGHT, height_word);
      end else begin
         write_register(CSR_IMAGE_HEIGHT, height_word);
         write_register(CSR_IMAGE_WIDTH, width_word);
      end
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned ew;
      int unsigned eh;
      int unsigned total;
      int unsigned poke_at;
      int          random_sent;
      int          phase;

      board        = new();
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pixel    = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      quiet_cycles = 0;
      ready_run    = 0;
      burst_mode   = 1'b0;
      new_palette();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A hand-built 3 x 3 frame. The centre sees equal up and left neighbours and
      // equal right and down neighbours, with alpha differing, so the copied words
      // show that the whole RGBA word travels. The corners carry all-ones and
      // all-zeros, and one pixel matches white on RGB only.
      set_size(16'd3, 16'd3);
      drive_pixel(32'hFFFF_FFFF);
      drive_pixel(32'h2200_00FF);
      drive_pixel(32'h0000_0000);
      drive_pixel(32'h1100_00FF);
      drive_pixel(32'h8012_3456);
      drive_pixel(32'h3300_FF00);
      drive_pixel(32'hFFFF_FFFF);
      drive_pixel(32'h4400_FF00);
      drive_pixel(32'h00FF_FFFF);
      wait_quiet(1);

      // Width zero (the upper data bits are dropped by the register) and height zero
      // both act as one: every pixel is a whole frame and releases its own block.
      set_size(16'hF800, 16'h0000);
      drive_pixel(32'hDEAD_BEEF);
      drive_pixel(32'h2152_4110);
      drive_pixel(32'hFFFF_FFFF);
      wait_quiet(1);

      // A single-row frame: only the bottom-row path, left and right borders replicated.
      set_size(16'd4, 16'd1);
      drive_pixel(32'h0100_0001);
      drive_pixel(32'h0200_0001);
      drive_pixel(32'h0300_0002);
      drive_pixel(32'h0400_0001);
      wait_quiet(1);

      // One column, the tallest frame: left and right neighbours always replicated.
      set_size(16'd1, 16'hFFFF);
      drive_pixel(32'h0000_00AA);
      drive_pixel(32'h0000_00BB);
      drive_pixel(32'h0000_00AA);
      drive_pixel(32'h0000_00BB);
      drive_pixel(32'hFF00_00BB);
      wait_quiet(1);

      // A register value above the maximum width acts as the maximum. A single row,
      // started but not finished, so every pixel after the first releases a block.
      set_size(16'h07FF, 16'd1);
      new_palette();
      repeat (WIDE_ITEMS) drive_pixel(make_pixel());
      wait_quiet(1);

      // Random phases: small frames, one or two whole frames each, sometimes cut short.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         new_palette();
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
         h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
         set_size({5'($urandom), 11'(w)}, 16'(h));
         ew    = (w == 0) ? 1 : w;
         eh    = (h == 0) ? 1 : h;
         total = $urandom_range(1, 2) * ew * eh;
         if ($urandom_range(0, 2) == 0) total = total + $urandom_range(0, ew * eh - 1);
         if (total > RANDOM_ITEMS - random_sent) total = RANDOM_ITEMS - random_sent;
         // Now and then a write to an unused index lands mid-frame; the frame must go on.
         poke_at = (phase == 0 || $urandom_range(0, 3) == 0) ? total / 2 : total + 1;
         for (int unsigned i = 0; i < total; i++) begin
            if (i == poke_at) begin
               wait_quiet(1);
               write_register(CSR_UNUSED_IDX, 16'($urandom));
            end else if ($urandom_range(0, 29) == 0) begin
               wait_quiet(0);
            end
            drive_pixel(make_pixel());
            random_sent++;
         end
         wait_quiet(1);
         phase++;
      end

      wait_quiet(1);
      if (board.pending() != 0) board.mismatches += board.pending();
      if (board.mismatches == 0)
         $display("scale2x_pixel_upscaler_top: match");
      else
         $display("scale2x_pixel_upscaler_top: mismatch");
      $finish;
   end

endmodule

### scale2x_pixel_upscaler_top.f
+incdir+hdl
hdl/s2x_pkg.sv
hdl/s2x_ram.sv
hdl/s2x_kernel.sv
hdl/s2x_front.sv
hdl/s2x_emit.sv
hdl/scale2x_pixel_upscaler_top.sv
verif/scale2x_pixel_upscaler_top_tb.sv
